// ===== design/postfix_expression_evaluator_assert.svh =====
// assertion macros for the postfix expression evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define PFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFE_ASSERT(lbl, prop, msg)

`define PFE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/pfe_pkg.sv =====
// shared constants, types and command/status structs of the postfix evaluator
`default_nettype none

package pfe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int SYM_W       = 8;
  localparam int OUT_W       = 32;
  localparam int STAT_W      = 3;

  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [DEPTH_W-1:0]     addr_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic start_div;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic can_op;
    logic b_zero;
    logic last;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/pfe_sym_if.sv =====
// valid/ready channel interfaces for symbols in and results out
`default_nettype none

interface pfe_sym_if import pfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfe_res_if import pfe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic [STAT_W-1:0]       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== design/pfe_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none

module pfe_div import pfe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  value_t dividend_i,
  input  value_t divisor_i,
  output logic   done_o,
  output value_t quotient_o
);

  logic                 busy_q, done_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  value_t               rem_q, quo_q, den_q;
  value_t               mag_a, mag_b;
  logic [VALUE_WIDTH:0] shifted, trial;

  assign mag_a   = dividend_i[VALUE_WIDTH-1] ? (~dividend_i + value_t'(1)) : dividend_i;
  assign mag_b   = divisor_i[VALUE_WIDTH-1]  ? (~divisor_i + value_t'(1))  : divisor_i;
  assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_a;
      den_q <= mag_b;
      neg_q <= dividend_i[VALUE_WIDTH-1] ^ divisor_i[VALUE_WIDTH-1];
    end else if (busy_q) begin
      if (!trial[VALUE_WIDTH]) begin
        rem_q <= trial[VALUE_WIDTH-1:0];
        quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= shifted[VALUE_WIDTH-1:0];
        quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + value_t'(1)) : quo_q;

endmodule

`default_nettype wire

// ===== design/pfe_datapath.sv =====
// operand stack memory, arithmetic, sticky status and result register
`default_nettype none

module pfe_datapath import pfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic              last_i,
  output stat_t             stat_o,
  output logic [OUT_W-1:0]  value_o,
  output logic [STAT_W-1:0] status_o
);

  value_t           mem [STACK_DEPTH];
  logic [SYM_W-1:0] sym_q;
  logic             last_q;
  value_t           a_q, b_q, top_q;
  cnt_t             cnt_q, cnt_d, cnt_m1, cnt_m2;
  status_e          err_q, flag, emit_status;
  logic [OUT_W-1:0] value_q;
  status_e          status_q;

  logic   is_add, is_sub, is_mul, is_div, is_op, can_op, full, b_zero;
  logic   push_en, div_done;
  addr_t  push_addr;
  value_t push_val, top_d, digit, alu_res, op_res, quo;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);

  assign is_add = (sym_q == SYM_ADD);
  assign is_sub = (sym_q == SYM_SUB);
  assign is_mul = (sym_q == SYM_MUL);
  assign is_div = (sym_q == SYM_DIV);
  assign is_op  = is_add | is_sub | is_mul | is_div;
  assign can_op = (cnt_q >= CNT_W'(2));
  assign full   = (cnt_q >= CNT_W'(STACK_DEPTH));
  assign b_zero = (b_q == '0);
  assign digit  = value_t'(sym_q) - value_t'(SYM_ZERO);

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    alu_res = a_q + b_q;
    if (is_sub) begin
      alu_res = a_q - b_q;
    end else if (is_mul) begin
      alu_res = a_q * b_q;
    end
  end

  assign op_res = is_div ? (b_zero ? '0 : quo) : alu_res;

  // stack update for the current symbol
  always_comb begin
    push_en   = 1'b0;
    push_addr = cnt_q[DEPTH_W-1:0];
    push_val  = digit;
    cnt_d     = cnt_q;
    flag      = ST_OK;
    top_d     = b_q;
    if (is_op) begin
      if (!can_op) begin
        flag = ST_UNDERFLOW;
      end else begin
        push_en   = 1'b1;
        push_addr = cnt_m2[DEPTH_W-1:0];
        push_val  = op_res;
        cnt_d     = cnt_m1;
        if (is_div && b_zero) begin
          flag = ST_DIVZERO;
        end
      end
    end else if (full) begin
      flag = ST_OVERFLOW;
    end else begin
      push_en = 1'b1;
      cnt_d   = cnt_q + CNT_W'(1);
    end
    if (push_en) begin
      top_d = push_val;
    end
  end

  always_comb begin
    if (err_q != ST_OK) begin
      emit_status = err_q;
    end else if (cnt_q == '0) begin
      emit_status = ST_EMPTY;
    end else begin
      emit_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= ST_OK;
    end else if (cmd_i.emit) begin
      cnt_q <= '0;
      err_q <= ST_OK;
    end else if (cmd_i.commit) begin
      cnt_q <= cnt_d;
      if (err_q == ST_OK) begin
        err_q <= flag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && push_en) begin
      mem[push_addr] <= push_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
      b_q    <= mem[cnt_m1[DEPTH_W-1:0]];
      a_q    <= mem[cnt_m2[DEPTH_W-1:0]];
    end
    if (cmd_i.commit) begin
      top_q <= top_d;
    end
    if (cmd_i.emit) begin
      value_q  <= (cnt_q == '0) ? '0 : OUT_W'($signed(top_q));
      status_q <= emit_status;
    end
  end

  assign stat_o.is_div   = is_div;
  assign stat_o.can_op   = can_op;
  assign stat_o.b_zero   = b_zero;
  assign stat_o.last     = last_q;
  assign stat_o.div_done = div_done;

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ===== design/pfe_ctrl.sv =====
// sequencing state machine and output valid flag
`default_nettype none

module pfe_ctrl import pfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIVW = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_div && stat_i.can_op && !stat_i.b_zero) begin
          cmd_o.start_div = 1'b1;
          state_d         = S_DIVW;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.last ? S_EMIT : S_IDLE;
        end
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/postfix_expression_evaluator.sv =====
// top level of the postfix expression evaluator
// Usage:
// sym_i carries one expression character per transaction (symbol, last);
// res_o carries one transaction per expression (value, status), after the
// character marked last.
// A digit or operator is accepted with a load that reads the two top stack
// entries from the operand memory; the execute state then computes and
// writes the result back before the next ready. A '/' with two operands and
// a non-zero divisor first waits in the divide state for the bit-serial divider.
// The character marked last then goes through the emit state, which loads the
// result register and sets its valid, waiting while an earlier result is untaken.
// Status codes: 0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 empty.
// The first error of an expression is kept until its result is loaded for output.
// Reset empties the stack and clears the status; no clearing pass is needed.
// A stalled result stays in the output register while the next expression
// is taken in; only the following last character waits for it to drain.
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module postfix_expression_evaluator import pfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  pfe_sym_if.sink   sym_i,
  pfe_res_if.source res_o
);

  cmd_t              cmd;
  stat_t             stat;
  logic [OUT_W-1:0]  value;
  logic [STAT_W-1:0] status;

  pfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sym_i.valid),
    .in_ready_o  (sym_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pfe_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .symbol_i (sym_i.symbol),
    .last_i   (sym_i.last),
    .stat_o   (stat),
    .value_o  (value),
    .status_o (status)
  );

  assign res_o.value  = $signed(value);
  assign res_o.status = status;

  `PFE_ASSERT(a_cmd_exclusive, $onehot0(cmd), "more than one datapath command at once")
  `PFE_ASSERT(a_emit_on_last, !cmd.emit || stat.last, "result emitted for a non-final symbol")
  `PFE_ASSERT(a_div_done_commits, !stat.div_done || cmd.commit, "divide finished without commit")
  `PFE_ASSERT_NEXT(a_div_blocks_input, cmd.start_div, !sym_i.ready, "input taken during divide")

endmodule

`default_nettype wire
